// ----- rtl/core/psc_pkg.sv -----
// Shared constants, register codes and helpers for the PID speed controller.
`default_nettype none

package psc_pkg;

   // Fixed-point format and datapath widths.
   localparam int FRAC_BITS = 16;
   localparam int CFG_W     = 31;
   localparam int DATA_W    = 32;
   localparam int ERR_W     = 33;
   localparam int WIDE_W    = 34;
   localparam int HI_W      = WIDE_W - FRAC_BITS;
   localparam int PH_W      = CFG_W + HI_W;
   localparam int PL_W      = CFG_W + FRAC_BITS;
   localparam int TERM_W    = CFG_W + WIDE_W - FRAC_BITS;
   localparam int SUM_W     = TERM_W + 3;
   localparam int LANES     = 3;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_DEAD_BAND      = 3'd3,
      CSR_INTEGRAL_ZONE  = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5,
      CSR_MIN_DRIVE      = 3'd6
   } csr_index_type;

   // Magnitude of a signed wide value; the most negative value still fits unsigned.
   function automatic logic [WIDE_W-1:0] magnitude(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] m;
      m = v[WIDE_W-1] ? (~v + 1'b1) : v;
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pid_speed_controller_unit.sv -----
// Pipelined fixed-point PID speed controller with dead band, integral zone and clamps.
// Throughput: one word per cycle unless stalled; the integral and last-error state update per word.
// The pipeline stalls as a whole only while a presented result word is not taken.
// Reset is synchronous and active high; it clears gains, limits, state and valid flags.
`default_nettype none

module pid_speed_controller_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // Request channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_cmd,
   input  wire logic signed [psc_pkg::DATA_W-1:0] req_target,
   input  wire logic signed [psc_pkg::DATA_W-1:0] req_feedback,
   input  wire logic [psc_pkg::CFG_W-1:0]      req_max_drive,
   // Result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic signed [psc_pkg::DATA_W-1:0] rsp_drive,
   // Configuration channel
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [2:0]                     csr_index,
   input  wire logic [psc_pkg::CFG_W-1:0]      csr_data
);

   localparam int F = psc_pkg::FRAC_BITS;

   // Configuration registers.
   logic [psc_pkg::CFG_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [psc_pkg::CFG_W-1:0] dead_band_ff, integral_zone_ff, integral_limit_ff, min_drive_ff;

   // Controller state.
   logic signed [psc_pkg::DATA_W-1:0] integral_sum_ff, integral_sum_in;
   logic signed [psc_pkg::ERR_W-1:0]  previous_error_ff, previous_error_in;

   // Stage 1: request register.
   logic                              s1_valid_ff;
   logic                              s1_cmd_ff;
   logic signed [psc_pkg::DATA_W-1:0] s1_target_ff, s1_feedback_ff;
   logic [psc_pkg::CFG_W-1:0]         s1_max_ff;

   // Stage 2: error, integral and derivative.
   logic                              s2_valid_ff;
   logic                              s2_zero_ff, s2_zero_in;
   logic signed [psc_pkg::WIDE_W-1:0] s2_err_ff, s2_err_in;
   logic signed [psc_pkg::DATA_W-1:0] s2_integral_ff;
   logic signed [psc_pkg::WIDE_W-1:0] s2_deriv_ff, s2_deriv_in;
   logic [psc_pkg::CFG_W-1:0]         s2_max_ff;

   // Stage 3: partial products of the three terms.
   logic                              s3_valid_ff;
   logic                              s3_zero_ff;
   logic [psc_pkg::CFG_W-1:0]         s3_max_ff;
   logic [psc_pkg::PH_W-1:0]          s3_ph_ff [psc_pkg::LANES];
   logic [psc_pkg::PH_W-1:0]          s3_ph_in [psc_pkg::LANES];
   logic [psc_pkg::CFG_W-1:0]         s3_pl_ff [psc_pkg::LANES];
   logic [psc_pkg::CFG_W-1:0]         s3_pl_in [psc_pkg::LANES];
   logic [psc_pkg::LANES-1:0]         s3_neg_ff, s3_neg_in;

   // Stage 4: summed drive before clamping.
   logic                              s4_valid_ff;
   logic                              s4_zero_ff;
   logic [psc_pkg::CFG_W-1:0]         s4_max_ff;
   logic signed [psc_pkg::SUM_W-1:0]  s4_sum_ff, s4_sum_in;

   // Output register.
   logic                              rsp_valid_ff;
   logic signed [psc_pkg::DATA_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic advance;

   // The whole pipeline moves unless a presented result word is held.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         dead_band_ff      <= '0;
         integral_zone_ff  <= '0;
         integral_limit_ff <= '0;
         min_drive_ff      <= '0;
      end else if (csr_valid) begin
         case (psc_pkg::csr_index_type'(csr_index))
            psc_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_data;
            psc_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_data;
            psc_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_data;
            psc_pkg::CSR_DEAD_BAND:      dead_band_ff      <= csr_data;
            psc_pkg::CSR_INTEGRAL_ZONE:  integral_zone_ff  <= csr_data;
            psc_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_data;
            psc_pkg::CSR_MIN_DRIVE:      min_drive_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 2 logic: error, dead band test, integral update with zone and clamp.
   logic signed [psc_pkg::ERR_W-1:0]  err;
   logic [psc_pkg::WIDE_W-1:0]        aerr;
   logic                              active;
   logic signed [psc_pkg::WIDE_W-1:0] isum_cand;
   logic signed [psc_pkg::WIDE_W-1:0] lim_pos, lim_neg;
   logic signed [psc_pkg::DATA_W-1:0] integral_new;

   always_comb begin
      err = psc_pkg::ERR_W'(s1_target_ff) - psc_pkg::ERR_W'(s1_feedback_ff);
      s2_err_in = psc_pkg::WIDE_W'(err);
      aerr = psc_pkg::magnitude(s2_err_in);
      active = aerr > psc_pkg::WIDE_W'(dead_band_ff);
      lim_pos = $signed({3'b000, integral_limit_ff});
      lim_neg = -lim_pos;
      // Accumulate inside the zone, otherwise restart from zero.
      if (aerr < psc_pkg::WIDE_W'(integral_zone_ff)) begin
         isum_cand = psc_pkg::WIDE_W'(integral_sum_ff) + s2_err_in;
      end else begin
         isum_cand = '0;
      end
      if (isum_cand < lim_neg) begin
         isum_cand = lim_neg;
      end
      if (isum_cand > lim_pos) begin
         isum_cand = lim_pos;
      end
      integral_new = isum_cand[psc_pkg::DATA_W-1:0];
      s2_deriv_in = s2_err_in - psc_pkg::WIDE_W'(previous_error_ff);
      s2_zero_in = s1_cmd_ff || !active;
      // State follows the command: clear, or update on a run step.
      if (s1_cmd_ff) begin
         integral_sum_in   = '0;
         previous_error_in = '0;
      end else begin
         integral_sum_in   = active ? integral_new : integral_sum_ff;
         previous_error_in = err;
      end
   end

   // Stage 3 logic: magnitude split into high and low parts, two narrow products per term.
   logic [psc_pkg::CFG_W-1:0]         lane_gain [psc_pkg::LANES];
   logic signed [psc_pkg::WIDE_W-1:0] lane_val  [psc_pkg::LANES];
   logic [psc_pkg::WIDE_W-1:0]        lane_mag  [psc_pkg::LANES];
   logic [psc_pkg::PL_W-1:0]          lane_pl   [psc_pkg::LANES];

   always_comb begin
      lane_gain[0] = gain_p_ff;
      lane_gain[1] = gain_i_ff;
      lane_gain[2] = gain_d_ff;
      lane_val[0]  = s2_err_ff;
      lane_val[1]  = psc_pkg::WIDE_W'(s2_integral_ff);
      lane_val[2]  = s2_deriv_ff;
      for (int k = 0; k < psc_pkg::LANES; k++) begin
         lane_mag[k]  = psc_pkg::magnitude(lane_val[k]);
         s3_neg_in[k] = lane_val[k][psc_pkg::WIDE_W-1];
         s3_ph_in[k]  = psc_pkg::PH_W'(lane_gain[k])
                        * psc_pkg::PH_W'(lane_mag[k][psc_pkg::WIDE_W-1:F]);
         lane_pl[k]   = psc_pkg::PL_W'(lane_gain[k]) * psc_pkg::PL_W'(lane_mag[k][F-1:0]);
         s3_pl_in[k]  = lane_pl[k][psc_pkg::PL_W-1:F];
      end
   end

   // Stage 4 logic: rebuild each signed term and sum them exactly.
   logic [psc_pkg::TERM_W-1:0]       term_mag [psc_pkg::LANES];
   logic signed [psc_pkg::SUM_W-1:0] term     [psc_pkg::LANES];

   always_comb begin
      for (int k = 0; k < psc_pkg::LANES; k++) begin
         term_mag[k] = psc_pkg::TERM_W'(s3_ph_ff[k]) + psc_pkg::TERM_W'(s3_pl_ff[k]);
         term[k] = s3_neg_ff[k] ? -$signed(psc_pkg::SUM_W'(term_mag[k]))
                                :  $signed(psc_pkg::SUM_W'(term_mag[k]));
      end
      s4_sum_in = term[0] + term[1] + term[2];
   end

   // Output logic: clamp to the step's limit, then lift a nonzero drive to the minimum; zero-flagged words give zero.
   logic signed [psc_pkg::SUM_W-1:0] speed, maxd, mind;

   always_comb begin
      maxd  = $signed(psc_pkg::SUM_W'(s4_max_ff));
      mind  = $signed(psc_pkg::SUM_W'(min_drive_ff));
      speed = s4_sum_ff;
      if (speed < -maxd) begin
         speed = -maxd;
      end
      if (speed > maxd) begin
         speed = maxd;
      end
      if (speed > 0 && speed < mind) begin
         speed = mind;
      end
      if (speed < 0 && speed > -mind) begin
         speed = -mind;
      end
      if (s4_zero_ff) begin
         speed = '0;
      end
      rsp_drive_in = speed[psc_pkg::DATA_W-1:0];
   end

   // Pipeline control and state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         s4_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         integral_sum_ff   <= '0;
         previous_error_ff <= '0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
         if (s1_valid_ff) begin
            integral_sum_ff   <= integral_sum_in;
            previous_error_ff <= previous_error_in;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff      <= req_cmd;
         s1_target_ff   <= req_target;
         s1_feedback_ff <= req_feedback;
         s1_max_ff      <= req_max_drive;
         s2_zero_ff     <= s2_zero_in;
         s2_err_ff      <= s2_err_in;
         s2_integral_ff <= integral_new;
         s2_deriv_ff    <= s2_deriv_in;
         s2_max_ff      <= s1_max_ff;
         s3_zero_ff     <= s2_zero_ff;
         s3_max_ff      <= s2_max_ff;
         s3_neg_ff      <= s3_neg_in;
         for (int k = 0; k < psc_pkg::LANES; k++) begin
            s3_ph_ff[k] <= s3_ph_in[k];
            s3_pl_ff[k] <= s3_pl_in[k];
         end
         s4_zero_ff     <= s3_zero_ff;
         s4_max_ff      <= s3_max_ff;
         s4_sum_ff      <= s4_sum_in;
         rsp_drive_ff   <= rsp_drive_in;
      end
   end

`ifndef SYNTHESIS
   // A clear command leaves both state registers at zero.
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_cmd_ff) |=>
         (integral_sum_ff == '0 && previous_error_ff == '0))
      else $error("state not cleared by clear command");

   // State changes only when a word leaves the request register.
   assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=>
         ($stable(integral_sum_ff) && $stable(previous_error_ff)))
      else $error("controller state changed without a word");

   // A word flagged for zero drive comes out as zero.
   assert property (@(posedge clock) disable iff (reset)
      (advance && s4_valid_ff && s4_zero_ff) |=> (rsp_drive_ff == '0))
      else $error("zero drive word gave nonzero output");

   // A result word appears only after a word sat in the last stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s4_valid_ff))
      else $error("result word without a source");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the PID speed controller: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb;

   localparam int               LATENCY   = 4;
   localparam int               PHASE_LEN = 150;
   localparam logic [30:0]      MAX31     = 31'h7FFF_FFFF;
   localparam logic [30:0]      ONE       = 31'h0001_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // One request word as the block sees it.
   typedef struct packed {
      logic                                 cmd;
      logic signed [psc_pkg::DATA_W-1:0]    target;
      logic signed [psc_pkg::DATA_W-1:0]    feedback;
      logic [psc_pkg::CFG_W-1:0]            max_drive;
   } drive_request_type;

   // Tracks the controller state and the drive values still owed by the block.
   class drive_tracker;
      logic [psc_pkg::CFG_W-1:0]         gain_p, gain_i, gain_d;
      logic [psc_pkg::CFG_W-1:0]         dead_band, integral_zone, integral_limit, min_drive;
      longint                            integral_sum;
      longint                            previous_error;
      logic signed [psc_pkg::DATA_W-1:0] pending_drives[$];
      int                                mismatches;

      function void clear_all();
         gain_p = '0; gain_i = '0; gain_d = '0;
         dead_band = '0; integral_zone = '0; integral_limit = '0; min_drive = '0;
         integral_sum = 0;
         previous_error = 0;
         pending_drives.delete();
         mismatches = 0;
      endfunction

      function void note_config(psc_pkg::csr_index_type idx, logic [psc_pkg::CFG_W-1:0] value);
         case (idx)
            psc_pkg::CSR_GAIN_P:         gain_p = value;
            psc_pkg::CSR_GAIN_I:         gain_i = value;
            psc_pkg::CSR_GAIN_D:         gain_d = value;
            psc_pkg::CSR_DEAD_BAND:      dead_band = value;
            psc_pkg::CSR_INTEGRAL_ZONE:  integral_zone = value;
            psc_pkg::CSR_INTEGRAL_LIMIT: integral_limit = value;
            psc_pkg::CSR_MIN_DRIVE:      min_drive = value;
            default: ;
         endcase
      endfunction

      // Gain times value, scaled down by the fraction bits, truncated towards zero.
      function longint scaled_term(logic [psc_pkg::CFG_W-1:0] gain, longint v);
         logic [63:0] mag, hi, lo, prod;
         mag  = (v < 0) ? 64'(-v) : 64'(v);
         hi   = mag >> psc_pkg::FRAC_BITS;
         lo   = mag & ((64'd1 << psc_pkg::FRAC_BITS) - 64'd1);
         prod = 64'(gain) * hi + ((64'(gain) * lo) >> psc_pkg::FRAC_BITS);
         return (v < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      // Works out the drive for an accepted request and updates the loop state.
      function void note_request(drive_request_type rq);
         longint err, abs_err, deriv, speed, lim, maxd, mind;
         if (rq.cmd) begin
            integral_sum = 0;
            previous_error = 0;
            pending_drives.push_back('0);
            return;
         end
         err     = longint'(rq.target) - longint'(rq.feedback);
         abs_err = (err < 0) ? -err : err;
         maxd    = longint'(rq.max_drive);
         speed   = 0;
         if (abs_err > longint'(dead_band)) begin
            if (abs_err < longint'(integral_zone)) begin
               integral_sum = integral_sum + err;
            end else begin
               integral_sum = 0;
            end
            lim = longint'(integral_limit);
            if (integral_sum < -lim) integral_sum = -lim;
            if (integral_sum > lim) integral_sum = lim;
            deriv = err - previous_error;
            speed = scaled_term(gain_p, err) + scaled_term(gain_i, integral_sum)
                  + scaled_term(gain_d, deriv);
            if (speed < -maxd) speed = -maxd;
            if (speed > maxd) speed = maxd;
            // The minimum is applied last, so it may exceed the per-step limit.
            mind = longint'(min_drive);
            if (speed > 0 && speed < mind) speed = mind;
            if (speed < 0 && speed > -mind) speed = -mind;
         end
         previous_error = err;
         pending_drives.push_back(speed[31:0]);
      endfunction

      task report(string msg);
         mismatches++;
         $display("MISMATCH: %s", msg);
      endtask

      task check_drive(logic signed [psc_pkg::DATA_W-1:0] got);
         logic signed [psc_pkg::DATA_W-1:0] want;
         if (pending_drives.size() == 0) begin
            report($sformatf("drive 0x%08h arrived with nothing outstanding", got));
            return;
         end
         want = pending_drives.pop_front();
         if (got !== want) begin
            report($sformatf("drive got %0d (0x%08h), want %0d (0x%08h)",
                             got, got, want, want));
         end
      endtask

      function int pending();
         return pending_drives.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_cmd;
   logic signed [psc_pkg::DATA_W-1:0] req_target;
   logic signed [psc_pkg::DATA_W-1:0] req_feedback;
   logic [psc_pkg::CFG_W-1:0]         req_max_drive;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [psc_pkg::DATA_W-1:0] rsp_drive;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [2:0]                        csr_index;
   logic [psc_pkg::CFG_W-1:0]         csr_data;

   drive_tracker tracker = new;

   logic [psc_pkg::CFG_W-1:0] cur_dead_band;
   logic [psc_pkg::CFG_W-1:0] cur_zone;
   int words_sent;
   int clears_sent;
   int drives_checked;
   int settings_used;
   int stall_cycle;
   int burst_left;

   pid_speed_controller_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_target    (req_target),
      .req_feedback  (req_feedback),
      .req_max_drive (req_max_drive),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_drive     (rsp_drive),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // The receiver cycles through its own stall patterns, including full-rate stretches.
   always @(negedge clock) begin
      case ((stall_cycle / 97) % 4)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         2: rsp_ready = (stall_cycle % 5) != 0;
         default: rsp_ready = (stall_cycle % 16) < 4;
      endcase
      stall_cycle++;
   end

   // Every result word taken is compared with the oldest outstanding drive.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_drive(rsp_drive);
         drives_checked++;
      end
   end

   function automatic drive_request_type make_word(logic cmd, logic signed [31:0] target,
                                                   logic signed [31:0] feedback,
                                                   logic [30:0] max_drive);
      drive_request_type rq;
      rq.cmd       = cmd;
      rq.target    = target;
      rq.feedback  = feedback;
      rq.max_drive = max_drive;
      return rq;
   endfunction

   // A random 31-bit value with a random magnitude, so small and large settings both occur.
   function automatic logic [30:0] random_setting();
      return 31'(($urandom() & 32'h7FFF_FFFF) >> $urandom_range(0, 30));
   endfunction

   // Errors are steered towards the dead band and integral zone edges where the logic turns.
   function automatic drive_request_type random_request();
      drive_request_type rq;
      longint            err, fb, tgt, span;
      int                pick;
      rq.cmd = ($urandom_range(0, 39) == 0);
      pick   = $urandom_range(0, 9);
      fb     = longint'($signed($urandom()));
      span   = (cur_zone == 0) ? longint'(32'h0010_0000) : 2 * longint'(cur_zone);
      if (span > longint'(MAX31)) span = longint'(MAX31);
      case (pick)
         0, 1: err = longint'($signed($urandom())) - fb;
         2: err = longint'(cur_dead_band) + longint'($urandom_range(0, 2)) - 1;
         3: err = longint'(cur_zone) + longint'($urandom_range(0, 2)) - 1;
         9: err = longint'($urandom_range(0, 3));
         default: err = longint'($urandom_range(0, 32'(span)));
      endcase
      if (pick != 0 && pick != 1 && $urandom_range(0, 1) == 1) err = -err;
      tgt = fb + err;
      if (tgt > longint'(S32_MAX) || tgt < longint'(S32_MIN)) begin
         fb  = -(err >>> 1);
         tgt = fb + err;
      end
      rq.target   = tgt[31:0];
      rq.feedback = fb[31:0];
      case ($urandom_range(0, 9))
         0: rq.max_drive = '0;
         1: rq.max_drive = MAX31;
         2, 3, 4, 5: rq.max_drive = 31'($urandom());
         default: rq.max_drive = 31'($urandom_range(0, 32'h0004_0000));
      endcase
      return rq;
   endfunction

   // Presents one request word and holds it until the block takes it.
   task automatic send_word(input drive_request_type rq);
      @(negedge clock);
      req_valid     = 1'b1;
      req_cmd       = rq.cmd;
      req_target    = rq.target;
      req_feedback  = rq.feedback;
      req_max_drive = rq.max_drive;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(rq);
      words_sent++;
      if (rq.cmd) clears_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   // The sender holds back until every outstanding drive has come out of the pipeline.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(input psc_pkg::csr_index_type idx, input logic [30:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      tracker.note_config(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic program_regs(input logic [30:0] gp, gi, gd, db, zone, lim, mind);
      write_csr(psc_pkg::CSR_GAIN_P, gp);
      write_csr(psc_pkg::CSR_GAIN_I, gi);
      write_csr(psc_pkg::CSR_GAIN_D, gd);
      write_csr(psc_pkg::CSR_DEAD_BAND, db);
      write_csr(psc_pkg::CSR_INTEGRAL_ZONE, zone);
      write_csr(psc_pkg::CSR_INTEGRAL_LIMIT, lim);
      write_csr(psc_pkg::CSR_MIN_DRIVE, mind);
      cur_dead_band = db;
      cur_zone      = zone;
      settings_used++;
   endtask

   // Random words in bursts of random length, with random gaps and some long unbroken runs.
   task automatic run_random(input int count);
      int n;
      for (n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            pause_sender($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
         end
         send_word(random_request());
         burst_left--;
      end
   endtask

   // Main sequence.
   initial begin
      int phase;
      tracker.clear_all();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = 1'b0;
      req_target    = '0;
      req_feedback  = '0;
      req_max_drive = '0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      cur_dead_band = '0;
      cur_zone      = '0;
      words_sent = 0; clears_sent = 0; drives_checked = 0; settings_used = 0;
      stall_cycle = 0; burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // With the registers at their reset values every drive comes out as zero.
      send_word(make_word(1'b0, S32_MAX, S32_MIN, MAX31));
      send_word(make_word(1'b0, S32_MIN, S32_MAX, '0));
      send_word(make_word(1'b1, S32_MAX, S32_MAX, MAX31));
      wait_for_drain();

      // Directed: dead band edge, zone accumulation and reset, clamps, minimum, extremes.
      program_regs(ONE, ONE >> 2, ONE >> 1, 31'h100, 31'h10_0000, 31'h18_0000, 31'h800);
      send_word(make_word(1'b0, 32'sh100, 32'sh0, MAX31));
      send_word(make_word(1'b0, 32'sh101, 32'sh0, MAX31));
      send_word(make_word(1'b0, 32'sh0, 32'sh101, MAX31));
      send_word(make_word(1'b1, 32'sh0, 32'sh0, MAX31));
      repeat (4) send_word(make_word(1'b0, 32'sh8_0000, 32'sh0, MAX31));
      send_word(make_word(1'b0, 32'sh10_0000, 32'sh0, MAX31));
      send_word(make_word(1'b0, -32'sh5, 32'shF_FFFA, MAX31));
      send_word(make_word(1'b0, 32'sh0, 32'shF_FFFF, MAX31));
      send_word(make_word(1'b0, 32'sh8_0000, 32'sh0, 31'h400));
      send_word(make_word(1'b0, 32'sh8_0000, 32'sh0, '0));
      send_word(make_word(1'b0, S32_MAX, S32_MIN, MAX31));
      send_word(make_word(1'b0, S32_MIN, S32_MAX, MAX31));
      send_word(make_word(1'b0, S32_MIN, S32_MAX, 31'h7FFF));
      send_word(make_word(1'b1, S32_MIN, S32_MIN, '0));
      send_word(make_word(1'b0, 32'sh0, 32'sh3_0001, MAX31));
      wait_for_drain();

      // Random phases, each under its own register setting: the directed one, then extremes, then random ones.
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_regs(ONE, ONE >> 2, ONE >> 1, 31'h100, 31'h10_0000, 31'h18_0000,
                            31'h800);
            1: program_regs(MAX31, MAX31, MAX31, '0, MAX31, MAX31, '0);
            2: program_regs(31'h1, '0, '0, MAX31, '0, '0, MAX31);
            3: program_regs(ONE << 2, ONE, ONE << 3, 31'h40, 31'h4_0000, '0, MAX31);
            default: program_regs(random_setting(), random_setting(), random_setting(),
                                  random_setting(), random_setting(), random_setting(),
                                  random_setting());
         endcase
         run_random(PHASE_LEN);
         wait_for_drain();
      end

      if (tracker.pending() != 0) begin
         tracker.report($sformatf("%0d drives never came out", tracker.pending()));
      end
      $display("Sent %0d request words, %0d of them clears, under %0d register settings.",
               words_sent, clears_sent, settings_used);
      $display("Checked %0d drive words, %0d mismatches.", drives_checked,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog in case the block stops moving words.
   initial begin
      #5_000_000;
      $display("Run stopped by the watchdog.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
